### rtl/lfu_cache_replacement_assert.svh
// Assertion macros shared by the LFU cache checker.
`ifndef LFU_CACHE_REPLACEMENT_ASSERT_SVH
`define LFU_CACHE_REPLACEMENT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfu checker: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfu checker: assertion failed");

`endif

### rtl/lfu_pkg.sv
// Shared constants and types of the LFU cache with LRU tie break.
`default_nettype none

package lfu_pkg;

    localparam int KEY_BITS        = 32;
    localparam int VALUE_BITS      = 32;
    localparam int CAP_BITS        = 5;
    localparam int ENTRIES_DEF     = 16;
    localparam int COUNT_BITS_DEF  = 16;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef struct packed {
        logic is_target;
        logic ins;
        logic evict;
    } lfu_ctl_t;

endpackage

`default_nettype wire

### rtl/lfu_cache_replacement.sv
// Top level of the LFU cache with LRU tie break: sequencer, entry table and valid bits.
//
// Channel | Direction | Signals                                        | Moves
// s_      | in        | s_valid s_ready s_action s_lookup_key s_write_value | request
// m_      | out       | m_valid m_ready m_hit m_read_value             | result
// cfg_    | in        | cfg_valid cfg_ready cfg_data                   | capacity_in_use
//
// A get miss or a put at capacity zero takes only the scan pass; any other transaction
// takes both passes over the single read port of the entry table: one scan pass for the
// key match, free slot and victim, then one read-modify-write pass for ranks and counts.
// Reset clears the valid bits directly; no clearing pass is needed.
// A finished result waits in the output register while the next request is accepted.
`default_nettype none

module lfu_cache_replacement #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [lfu_pkg::KEY_BITS-1:0]      s_lookup_key,
    input  logic [lfu_pkg::VALUE_BITS-1:0]    s_write_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic [lfu_pkg::VALUE_BITS-1:0]    m_read_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lfu_pkg::CAP_BITS-1:0]      cfg_data
);
    import lfu_pkg::*;

    localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_BITS  = $clog2(ENTRIES + 1);
    localparam int RANK_BITS = IDX_BITS;
    localparam int CMP_BITS  = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;
    localparam int WORD_BITS = KEY_BITS + VALUE_BITS + COUNT_BITS + RANK_BITS;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_RESP   = 3'd4;

    localparam logic [OCC_BITS-1:0] IDX_END = OCC_BITS'(ENTRIES);

    logic [WORD_BITS-1:0] mem [ENTRIES];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_en;
    logic                 wr_en;
    logic [IDX_BITS-1:0]  rd_addr;
    logic [IDX_BITS-1:0]  wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    logic [2:0]            state_reg, state_next;
    logic [OCC_BITS-1:0]   idx_reg, idx_next;
    logic                  rdv_reg, rdv_next;
    logic [IDX_BITS-1:0]   rd_idx_reg, rd_idx_next;
    logic [CAP_BITS-1:0]   cap_reg, cap_next;
    logic [OCC_BITS-1:0]   occ_reg, occ_next;
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic                  m_valid_reg, m_valid_next;

    logic                  act_reg, act_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  found_reg, found_next;
    logic [IDX_BITS-1:0]   found_idx_reg, found_idx_next;
    logic [RANK_BITS-1:0]  found_rank_reg, found_rank_next;
    logic [VALUE_BITS-1:0] found_val_reg, found_val_next;
    logic                  best_valid_reg, best_valid_next;
    logic [IDX_BITS-1:0]   best_idx_reg, best_idx_next;
    logic [COUNT_BITS-1:0] best_count_reg, best_count_next;
    logic [RANK_BITS-1:0]  best_rank_reg, best_rank_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_BITS-1:0]   free_idx_reg, free_idx_next;
    logic [IDX_BITS-1:0]   tgt_idx_reg, tgt_idx_next;
    logic [RANK_BITS-1:0]  ref_rank_reg, ref_rank_next;
    logic                  ins_reg, ins_next;
    logic                  evict_reg, evict_next;
    logic                  res_hit_reg, res_hit_next;
    logic [VALUE_BITS-1:0] res_value_reg, res_value_next;
    logic                  m_hit_reg, m_hit_next;
    logic [VALUE_BITS-1:0] m_value_reg, m_value_next;

    logic [KEY_BITS-1:0]   ent_key;
    logic [VALUE_BITS-1:0] ent_value;
    logic [COUNT_BITS-1:0] ent_count;
    logic [RANK_BITS-1:0]  ent_rank;
    logic                  ent_valid;
    lfu_ctl_t              alu_ctl;
    logic                  key_match;
    logic                  victim_better;
    logic [RANK_BITS-1:0]  rank_new;
    logic [COUNT_BITS-1:0] count_new;
    logic                  has_room;

    assign ent_key   = rd_data_reg[WORD_BITS-1 -: KEY_BITS];
    assign ent_value = rd_data_reg[VALUE_BITS+COUNT_BITS+RANK_BITS-1 -: VALUE_BITS];
    assign ent_count = rd_data_reg[COUNT_BITS+RANK_BITS-1 -: COUNT_BITS];
    assign ent_rank  = rd_data_reg[RANK_BITS-1:0];
    assign ent_valid = valid_reg[rd_idx_reg];

    assign alu_ctl.is_target = (rd_idx_reg == tgt_idx_reg);
    assign alu_ctl.ins       = ins_reg;
    assign alu_ctl.evict     = evict_reg;

    assign has_room = (CMP_BITS'(occ_reg) < CMP_BITS'(cap_reg)) && (occ_reg < IDX_END);

    lfu_rank_alu #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_alu (
        .ctl           (alu_ctl),
        .ent_valid     (ent_valid),
        .ent_key       (ent_key),
        .cmp_key       (key_reg),
        .ent_count     (ent_count),
        .ent_rank      (ent_rank),
        .best_valid    (best_valid_reg),
        .best_count    (best_count_reg),
        .best_rank     (best_rank_reg),
        .ref_rank      (ref_rank_reg),
        .key_match     (key_match),
        .victim_better (victim_better),
        .rank_next     (rank_new),
        .count_next    (count_new)
    );

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        rdv_next        = 1'b0;
        rd_idx_next     = rd_idx_reg;
        cap_next        = cap_reg;
        occ_next        = occ_reg;
        valid_next      = valid_reg;
        m_valid_next    = m_valid_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_rank_next = found_rank_reg;
        found_val_next  = found_val_reg;
        best_valid_next = best_valid_reg;
        best_idx_next   = best_idx_reg;
        best_count_next = best_count_reg;
        best_rank_next  = best_rank_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        tgt_idx_next    = tgt_idx_reg;
        ref_rank_next   = ref_rank_reg;
        ins_next        = ins_reg;
        evict_next      = evict_reg;
        res_hit_next    = res_hit_reg;
        res_value_next  = res_value_reg;
        m_hit_next      = m_hit_reg;
        m_value_next    = m_value_reg;

        rd_en   = 1'b0;
        rd_addr = idx_reg[IDX_BITS-1:0];
        wr_en   = 1'b0;
        wr_addr = rd_idx_reg;
        wr_data = {((alu_ctl.is_target && ins_reg) ? key_reg : ent_key),
                   ((alu_ctl.is_target && (act_reg == ACT_PUT)) ? val_reg : ent_value),
                   count_new, rank_new};

        if (cfg_valid) begin
            cap_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    act_next        = s_action;
                    key_next        = s_lookup_key;
                    val_next        = s_write_value;
                    found_next      = 1'b0;
                    best_valid_next = 1'b0;
                    free_found_next = 1'b0;
                    idx_next        = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_reg != IDX_END) begin
                    rd_en       = 1'b1;
                    rdv_next    = 1'b1;
                    rd_idx_next = idx_reg[IDX_BITS-1:0];
                    idx_next    = OCC_BITS'(idx_reg + 1'b1);
                end else begin
                    state_next = ST_DECIDE;
                end
                if (rdv_reg) begin
                    if (key_match && !found_reg) begin
                        found_next      = 1'b1;
                        found_idx_next  = rd_idx_reg;
                        found_rank_next = ent_rank;
                        found_val_next  = ent_value;
                    end
                    if (victim_better) begin
                        best_valid_next = 1'b1;
                        best_idx_next   = rd_idx_reg;
                        best_count_next = ent_count;
                        best_rank_next  = ent_rank;
                    end
                    if (!ent_valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                end
            end
            ST_DECIDE: begin
                res_hit_next   = found_reg;
                res_value_next = ((act_reg == ACT_GET) && found_reg) ? found_val_reg : '0;
                idx_next       = '0;
                state_next     = ST_RESP;
                if (found_reg && ((act_reg == ACT_GET) || (cap_reg != '0))) begin
                    tgt_idx_next  = found_idx_reg;
                    ref_rank_next = found_rank_reg;
                    ins_next      = 1'b0;
                    evict_next    = 1'b0;
                    state_next    = ST_UPDATE;
                end else if ((act_reg == ACT_PUT) && (cap_reg != '0) && !found_reg) begin
                    if (has_room && free_found_reg) begin
                        tgt_idx_next = free_idx_reg;
                        ins_next     = 1'b1;
                        evict_next   = 1'b0;
                        occ_next     = OCC_BITS'(occ_reg + 1'b1);
                        state_next   = ST_UPDATE;
                    end else if (best_valid_reg) begin
                        tgt_idx_next  = best_idx_reg;
                        ref_rank_next = best_rank_reg;
                        ins_next      = 1'b1;
                        evict_next    = 1'b1;
                        state_next    = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                if (idx_reg != IDX_END) begin
                    rd_en       = 1'b1;
                    rdv_next    = 1'b1;
                    rd_idx_next = idx_reg[IDX_BITS-1:0];
                    idx_next    = OCC_BITS'(idx_reg + 1'b1);
                end else begin
                    state_next = ST_RESP;
                end
                if (rdv_reg && (ent_valid || alu_ctl.is_target)) begin
                    wr_en = 1'b1;
                    if (alu_ctl.is_target && ins_reg) begin
                        valid_next[rd_idx_reg] = 1'b1;
                    end
                end
            end
            ST_RESP: begin
                if (!m_valid_reg) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = res_hit_reg;
                    m_value_next = res_value_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            rdv_reg     <= 1'b0;
            cap_reg     <= CAP_RESET;
            occ_reg     <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            rdv_reg     <= rdv_next;
            cap_reg     <= cap_next;
            occ_reg     <= occ_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        act_reg        <= act_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        found_reg      <= found_next;
        found_idx_reg  <= found_idx_next;
        found_rank_reg <= found_rank_next;
        found_val_reg  <= found_val_next;
        best_valid_reg <= best_valid_next;
        best_idx_reg   <= best_idx_next;
        best_count_reg <= best_count_next;
        best_rank_reg  <= best_rank_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        tgt_idx_reg    <= tgt_idx_next;
        ref_rank_reg   <= ref_rank_next;
        ins_reg        <= ins_next;
        evict_reg      <= evict_next;
        res_hit_reg    <= res_hit_next;
        res_value_reg  <= res_value_next;
        m_hit_reg      <= m_hit_next;
        m_value_reg    <= m_value_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_read_value = m_value_reg;

endmodule

`default_nettype wire

### rtl/lfu_rank_alu.sv
// Shared compare and update unit applied to one table entry per cycle.
`default_nettype none

module lfu_rank_alu #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
    localparam int RANK_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  lfu_pkg::lfu_ctl_t                ctl,
    input  logic                             ent_valid,
    input  logic [lfu_pkg::KEY_BITS-1:0]     ent_key,
    input  logic [lfu_pkg::KEY_BITS-1:0]     cmp_key,
    input  logic [COUNT_BITS-1:0]            ent_count,
    input  logic [RANK_BITS-1:0]             ent_rank,
    input  logic                             best_valid,
    input  logic [COUNT_BITS-1:0]            best_count,
    input  logic [RANK_BITS-1:0]             best_rank,
    input  logic [RANK_BITS-1:0]             ref_rank,
    output logic                             key_match,
    output logic                             victim_better,
    output logic [RANK_BITS-1:0]             rank_next,
    output logic [COUNT_BITS-1:0]            count_next
);
    import lfu_pkg::*;

    always_comb begin
        key_match     = ent_valid && (ent_key == cmp_key);
        victim_better = ent_valid && (!best_valid || (ent_count < best_count) ||
                        ((ent_count == best_count) && (ent_rank > best_rank)));

        if (ctl.is_target) begin
            rank_next = '0;
        end else if (ctl.ins) begin
            if (ctl.evict && (ent_rank > ref_rank)) begin
                rank_next = ent_rank;
            end else begin
                rank_next = RANK_BITS'(ent_rank + 1'b1);
            end
        end else if (ent_rank < ref_rank) begin
            rank_next = RANK_BITS'(ent_rank + 1'b1);
        end else begin
            rank_next = ent_rank;
        end

        if (!ctl.is_target) begin
            count_next = ent_count;
        end else if (ctl.ins) begin
            count_next = COUNT_BITS'(1);
        end else if (ent_count == {COUNT_BITS{1'b1}}) begin
            count_next = ent_count;
        end else begin
            count_next = COUNT_BITS'(ent_count + 1'b1);
        end
    end

endmodule

`default_nettype wire

### rtl/lfu_checker.sv
// Port-level checker for the LFU cache, bound to the top level.
`default_nettype none

`include "lfu_cache_replacement_assert.svh"

module lfu_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_action,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_hit,
    input logic [lfu_pkg::VALUE_BITS-1:0]  m_read_value
);
    import lfu_pkg::*;

    logic pend_reg, pend_next;
    logic last_put_reg, last_put_next;
    logic m_valid_q_reg;

    always_comb begin
        pend_next     = pend_reg;
        last_put_next = last_put_reg;
        if (s_valid && s_ready) begin
            pend_next     = 1'b1;
            last_put_next = (s_action == ACT_PUT);
        end else if (m_valid && !m_valid_q_reg) begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= 1'b0;
            last_put_reg  <= 1'b0;
            m_valid_q_reg <= 1'b0;
        end else begin
            pend_reg      <= pend_next;
            last_put_reg  <= last_put_next;
            m_valid_q_reg <= m_valid;
        end
    end

    `LFU_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `LFU_ASSERT_SAME(a_result_has_request, aclk, aresetn, $rose(m_valid), pend_reg)
    `LFU_ASSERT_SAME(a_put_reads_zero, aclk, aresetn, $rose(m_valid) && last_put_reg, m_read_value == '0)
    `LFU_ASSERT_SAME(a_miss_reads_zero, aclk, aresetn, m_valid && !m_hit, m_read_value == '0)
    `LFU_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_hit) && $stable(m_read_value))

endmodule

bind lfu_cache_replacement lfu_checker u_lfu_checker (.*);

`default_nettype wire
